// ===== design/rsvs_pkg.sv =====
// ----------------------------------------------------------------------------
// rsvs_pkg
// Shared types and constants for the ramped stereo volume scaler.
// ----------------------------------------------------------------------------
package rsvs_pkg;

  // operation codes carried by each input transaction
  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_SAMPLE = 2'd0;
  localparam opcode_t OP_TICK   = 2'd1;
  localparam opcode_t OP_TARGET = 2'd2;
  localparam opcode_t OP_MUTE   = 2'd3;

  // fixed-point format of the gain (Q14)
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned Q_SHIFT  = 14;

  // product of a signed sample and an unsigned gain, plus rounding headroom
  localparam int unsigned PROD_W = SAMPLE_W + GAIN_W + 2;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (Q_SHIFT - 1);
  localparam logic [GAIN_W-1:0] RAMP_STEP_RESET = GAIN_W'(100);

  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // (s * g + half) >>> Q_SHIFT, wrapped to the sample width
  function automatic sample_t scale_sample(input sample_t s, input gain_t g);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] sum;
    prod = PROD_W'(s) * $signed({2'b00, g});
    sum  = prod + $signed(ROUND_HALF);
    return sum[Q_SHIFT +: SAMPLE_W];
  endfunction

endpackage

// ===== design/ramped_stereo_volume_scaler_top.sv =====
// ----------------------------------------------------------------------------
// ramped_stereo_volume_scaler_top
// Stereo Q14 volume scaler with a stepped gain ramp toward a target gain.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless out_ready holds back the output stage,
// and returns one result per transaction. A transaction is registered on
// acceptance, worked through one stage of logic (two 16x17 multipliers for
// the samples, an add, a subtract and compares for the gain ramp) and lands
// in the output register, where its result is presented until it is taken.
// Input and output stages each hold one
// transaction; the input side keeps accepting while a result waits, as long
// as the following stage can drain. The gain state is updated in the compute
// stage, so back-to-back transactions see each other's gain changes in order.
// Write cfg_ramp_step only while no transaction is in flight.
module ramped_stereo_volume_scaler_top (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_ramp_step,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rsvs_pkg::opcode_t    in_opcode,
  input  logic signed [15:0]   in_left_sample,
  input  logic signed [15:0]   in_right_sample,
  input  logic [15:0]          in_new_target,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_left_out,
  output logic signed [15:0]   out_right_out,
  output logic [15:0]          out_gain_now
);
  import rsvs_pkg::*;

  // configuration register
  gain_t ramp_step_r;

  // input stage
  logic    s1_valid_r;
  opcode_t s1_opcode_r;
  sample_t s1_left_r;
  sample_t s1_right_r;
  gain_t   s1_target_r;

  // gain state
  gain_t cur_gain_r, cur_gain_nxt;
  gain_t tgt_gain_r, tgt_gain_nxt;

  // output stage
  logic    out_valid_r;
  sample_t out_left_r, out_left_nxt;
  sample_t out_right_r, out_right_nxt;

  // flow control
  logic advance;
  logic s1_fire;
  logic in_fire;

  assign advance  = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  // ramp step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r <= RAMP_STEP_RESET;
    end else if (cfg_we) begin
      ramp_step_r <= cfg_ramp_step;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode_r <= in_opcode;
      s1_left_r   <= in_left_sample;
      s1_right_r  <= in_right_sample;
      s1_target_r <= in_new_target;
    end
  end

  // ramp arithmetic
  logic [GAIN_W:0] up_sum;
  logic [GAIN_W:0] down_diff;
  gain_t           ramp_gain;

  assign up_sum    = {1'b0, cur_gain_r} + {1'b0, ramp_step_r};
  assign down_diff = {1'b0, cur_gain_r} - {1'b0, ramp_step_r};

  always_comb begin
    ramp_gain = cur_gain_r;
    if (tgt_gain_r > cur_gain_r) begin
      // rising: clamp at target
      if (up_sum > {1'b0, tgt_gain_r}) begin
        ramp_gain = tgt_gain_r;
      end else begin
        ramp_gain = up_sum[GAIN_W-1:0];
      end
    end else if (tgt_gain_r < cur_gain_r) begin
      // falling: borrow or overshoot lands on target
      if (down_diff[GAIN_W] || (down_diff[GAIN_W-1:0] < tgt_gain_r)) begin
        ramp_gain = tgt_gain_r;
      end else begin
        ramp_gain = down_diff[GAIN_W-1:0];
      end
    end
  end

  // compute stage: state update and result
  always_comb begin
    cur_gain_nxt  = cur_gain_r;
    tgt_gain_nxt  = tgt_gain_r;
    out_left_nxt  = '0;
    out_right_nxt = '0;
    case (s1_opcode_r)
      OP_SAMPLE: begin
        out_left_nxt  = scale_sample(s1_left_r, cur_gain_r);
        out_right_nxt = scale_sample(s1_right_r, cur_gain_r);
      end
      OP_TICK: begin
        cur_gain_nxt = ramp_gain;
      end
      OP_TARGET: begin
        tgt_gain_nxt = s1_target_r;
      end
      OP_MUTE: begin
        cur_gain_nxt = '0;
        tgt_gain_nxt = '0;
      end
      default: begin
        cur_gain_nxt = cur_gain_r;
      end
    endcase
  end

  // gain state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_gain_r <= '0;
      tgt_gain_r <= '0;
    end else if (s1_fire) begin
      cur_gain_r <= cur_gain_nxt;
      tgt_gain_r <= tgt_gain_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_left_r  <= out_left_nxt;
      out_right_r <= out_right_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;
  assign out_gain_now  = cur_gain_r;

  // reported gain always matches the live gain state
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_gain_now == cur_gain_r))
    else $error("reported gain differs from gain state");

  // mute clears both gains
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_opcode_r == OP_MUTE)) |=> (cur_gain_r == '0 && tgt_gain_r == '0))
    else $error("mute did not clear gains");

  // a tick never carries the gain past the target when rising
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_opcode_r == OP_TICK) && (cur_gain_r <= tgt_gain_r))
      |=> (cur_gain_r <= tgt_gain_r))
    else $error("ramp overshot target");

  // samples and ticks leave the target alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && ((s1_opcode_r == OP_SAMPLE) || (s1_opcode_r == OP_TICK)))
      |=> $stable(tgt_gain_r))
    else $error("target changed without a set-target or mute");

  // an empty output stage never stalls the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output stage");

endmodule
